@@ rtl/core/ratm_pkg.sv @@
// Shared types, constants and functions of the three-row-memory ring automaton.
// No dependencies; every other file of the block refers to this package.
package ratm_pkg;

  localparam int GENERATIONS = 32;
  localparam int RING_CELLS  = 8;
  localparam int SEED_W      = 8;
  localparam int OUT_W       = 3;

  localparam int STAGES      = GENERATIONS - 3;

  localparam int RULE_WORDS  = 8;
  localparam int RULE_W      = 64;
  localparam int RULE_BITS   = RULE_WORDS * RULE_W;
  localparam int ADDR_W      = $clog2(RULE_BITS);
  localparam int RULE_IDX_W  = $clog2(RULE_WORDS);
  localparam int CFG_IDX_W   = RULE_IDX_W + 1;

  typedef logic [RING_CELLS-1:0] row_t;

  typedef struct packed {
    row_t g3;
    row_t g2;
    row_t g1;
  } rows_t;

  // Seed bits beyond the ring are dropped; ring cells beyond the seed start dead.
  function automatic row_t fit_seed(input logic [SEED_W-1:0] seed);
    row_t row;
    row = '0;
    for (int x = 0; x < RING_CELLS; x++) begin
      if (x < SEED_W) begin
        row[x] = seed[x];
      end
    end
    return row;
  endfunction

  function automatic row_t next_row(input rows_t rows, input logic [RULE_BITS-1:0] rule_table);
    row_t                fresh;
    logic [ADDR_W-1:0]   addr;
    int                  l;
    int                  r;
    fresh = '0;
    for (int x = 0; x < RING_CELLS; x++) begin
      l = (x == 0) ? RING_CELLS - 1 : x - 1;
      r = (x == RING_CELLS - 1) ? 0 : x + 1;
      addr = {rows.g3[r], rows.g3[x], rows.g3[l],
              rows.g2[r], rows.g2[x], rows.g2[l],
              rows.g1[r], rows.g1[x], rows.g1[l]};
      fresh[x] = rule_table[addr];
    end
    return fresh;
  endfunction

endpackage

@@ rtl/core/ratm_ifs.sv @@
// Channel interfaces of the ring automaton: seed rows, result and rule writes.
// Depends on ratm_pkg for the field widths.
interface ratm_seed_if;
  logic                          valid;
  logic                          ready;
  logic [ratm_pkg::SEED_W-1:0]   row_oldest;
  logic [ratm_pkg::SEED_W-1:0]   row_middle;
  logic [ratm_pkg::SEED_W-1:0]   row_newest;

  modport source (output valid, output row_oldest, output row_middle, output row_newest,
                  input ready);
  modport sink   (input valid, input row_oldest, input row_middle, input row_newest,
                  output ready);
endinterface

interface ratm_result_if;
  logic                          valid;
  logic                          ready;
  logic [ratm_pkg::OUT_W-1:0]    chosen_index;

  modport source (output valid, output chosen_index, input ready);
  modport sink   (input valid, input chosen_index, output ready);
endinterface

interface ratm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ratm_pkg::CFG_IDX_W-1:0]  index;
  logic [ratm_pkg::RULE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ring_automaton_three_row_memory.sv @@
// Top level of the three-row-memory ring automaton: rule registers and generation pipeline.
// Depends on ratm_pkg, the channel interfaces, ratm_rule_regs and ratm_gen_stage.
//
// Each seed item (three rows of an 8-cell ring) flows through 29 register stages, one
// stage per generation, each stage reading eight bits of the 512-bit rule table through
// a 512-to-1 selection per cell. A new item is taken every cycle while the output is not
// held back, and its result leaves after passing through all stages; a stalled output
// fills the pipeline, which then takes new items only as results leave. Rule words are
// written one per cycle and should be changed only while no item is in flight.
module ring_automaton_three_row_memory (
  input  logic        clk,
  input  logic        rst,
  ratm_seed_if.sink   seed,
  ratm_result_if.source result,
  ratm_cfg_if.sink    cfg
);

  logic [ratm_pkg::RULE_BITS-1:0] rule_table;
  logic                           valid [ratm_pkg::STAGES+1];
  logic                           ready [ratm_pkg::STAGES+1];
  ratm_pkg::rows_t                rows  [ratm_pkg::STAGES+1];

  ratm_rule_regs u_rule_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rule_table (rule_table)
  );

  assign valid[0]   = seed.valid;
  assign seed.ready = ready[0];
  assign rows[0].g3 = ratm_pkg::fit_seed(seed.row_oldest);
  assign rows[0].g2 = ratm_pkg::fit_seed(seed.row_middle);
  assign rows[0].g1 = ratm_pkg::fit_seed(seed.row_newest);

  for (genvar i = 0; i < ratm_pkg::STAGES; i++) begin : g_stage
    ratm_gen_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .rule_table (rule_table),
      .in_valid   (valid[i]),
      .in_ready   (ready[i]),
      .in_rows    (rows[i]),
      .out_valid  (valid[i+1]),
      .out_ready  (ready[i+1]),
      .out_rows   (rows[i+1])
    );
  end

  assign ready[ratm_pkg::STAGES] = result.ready;
  assign result.valid            = valid[ratm_pkg::STAGES];
  assign result.chosen_index     = {rows[ratm_pkg::STAGES].g1[0],
                                    rows[ratm_pkg::STAGES].g1[1],
                                    rows[ratm_pkg::STAGES].g1[2]};

endmodule

@@ rtl/core/ratm_rule_regs.sv @@
// Rule table registers: eight 64-bit words written over the configuration channel.
// Depends on ratm_pkg and ratm_cfg_if.
module ratm_rule_regs (
  input  logic                              clk,
  input  logic                              rst,
  ratm_cfg_if.sink                          cfg,
  output logic [ratm_pkg::RULE_BITS-1:0]    rule_table
);

  logic [ratm_pkg::RULE_W-1:0] rule_word [ratm_pkg::RULE_WORDS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ratm_pkg::RULE_WORDS; k++) begin
        rule_word[k] <= '0;
      end
    end else if (cfg.valid &&
                 cfg.index < ratm_pkg::CFG_IDX_W'(ratm_pkg::RULE_WORDS)) begin
      rule_word[cfg.index[ratm_pkg::RULE_IDX_W-1:0]] <= cfg.data;
    end
  end

  for (genvar k = 0; k < ratm_pkg::RULE_WORDS; k++) begin : g_flat
    assign rule_table[k*ratm_pkg::RULE_W +: ratm_pkg::RULE_W] = rule_word[k];
  end

endmodule

@@ rtl/core/ratm_gen_stage.sv @@
// One pipeline stage: computes one generation of the ring and shifts the row history.
// Depends on ratm_pkg.
module ratm_gen_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ratm_pkg::RULE_BITS-1:0]    rule_table,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ratm_pkg::rows_t                   in_rows,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ratm_pkg::rows_t                   out_rows
);

  ratm_pkg::rows_t rows_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    rows_next.g3 = in_rows.g2;
    rows_next.g2 = in_rows.g1;
    rows_next.g1 = ratm_pkg::next_row(in_rows, rule_table);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rows <= rows_next;
    end
  end

endmodule

@@ rtl/core/ratm_checker.sv @@
// Port-level checks of the ring automaton, bound to the top level.
// Depends on ratm_pkg and ring_automaton_three_row_memory.
module ratm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  localparam int CNT_W = $clog2(ratm_pkg::STAGES + 2);

  logic [CNT_W-1:0] in_flight;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_acc && !out_acc) begin
      in_flight <= in_flight + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      in_flight <= in_flight - CNT_W'(1);
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> !out_valid)
    else $error("result shown with no item in flight");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(ratm_pkg::STAGES))
    else $error("more items in flight than pipeline stages");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_flight == CNT_W'(ratm_pkg::STAGES) && !out_ready)
    else $error("input refused while the pipeline has room");

endmodule

bind ring_automaton_three_row_memory ratm_checker u_ratm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (seed.valid),
  .in_ready  (seed.ready),
  .out_valid (result.valid),
  .out_ready (result.ready)
);

@@ tb/tb_ring_automaton_three_row_memory.sv @@
`timescale 1ns / 1ps
// Testbench of the three-row-memory ring automaton: seed rows in, packed cells out.
// Depends on ratm_pkg, the channel interfaces and the ring_automaton_three_row_memory top.
module tb_ring_automaton_three_row_memory;

  localparam int QUIET_LIMIT = 4000;
  localparam int IDLE_HEAVY  = 81;
  localparam int IDLE_BOTH   = 23;
  localparam int PHASE_ITEMS = 85;
  localparam int LONG_HOLD   = 600;

  typedef enum int {
    RULE_WORD_0, RULE_WORD_1, RULE_WORD_2, RULE_WORD_3,
    RULE_WORD_4, RULE_WORD_5, RULE_WORD_6, RULE_WORD_7
  } rule_reg_t;

  logic clk;
  logic rst;

  ratm_seed_if   seed_ch ();
  ratm_result_if result_ch ();
  ratm_cfg_if    cfg_ch ();

  ring_automaton_three_row_memory dut (
    .clk    (clk),
    .rst    (rst),
    .seed   (seed_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [ratm_pkg::RULE_W-1:0]  rule_table [ratm_pkg::RULE_WORDS];
  logic [ratm_pkg::OUT_W-1:0]   pending_choices [$];
  int                           mismatches;
  int                           quiet_cycles;
  int                           seed_gap_pct;
  int                           result_stall_pct;
  int                           stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Runs the ring forward from the three seeds and packs cells 0, 1 and 2.
  function automatic logic [ratm_pkg::OUT_W-1:0] predict_choice(
      input logic [ratm_pkg::SEED_W-1:0] oldest,
      input logic [ratm_pkg::SEED_W-1:0] middle,
      input logic [ratm_pkg::SEED_W-1:0] newest);
    logic [ratm_pkg::RING_CELLS-1:0] g1;
    logic [ratm_pkg::RING_CELLS-1:0] g2;
    logic [ratm_pkg::RING_CELLS-1:0] g3;
    logic [ratm_pkg::RING_CELLS-1:0] fresh;
    logic [8:0]                      addr;
    int                              l;
    int                              r;
    g3 = oldest;
    g2 = middle;
    g1 = newest;
    for (int gen = 3; gen < ratm_pkg::GENERATIONS; gen++) begin
      for (int x = 0; x < ratm_pkg::RING_CELLS; x++) begin
        l = (x + ratm_pkg::RING_CELLS - 1) % ratm_pkg::RING_CELLS;
        r = (x + 1) % ratm_pkg::RING_CELLS;
        addr[0] = g1[l];
        addr[1] = g1[x];
        addr[2] = g1[r];
        addr[3] = g2[l];
        addr[4] = g2[x];
        addr[5] = g2[r];
        addr[6] = g3[l];
        addr[7] = g3[x];
        addr[8] = g3[r];
        fresh[x] = rule_table[addr[8:6]][addr[5:0]];
      end
      g3 = g2;
      g2 = g1;
      g1 = fresh;
    end
    return {g1[0], g1[1], g1[2]};
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (seed_ch.valid && seed_ch.ready || result_ch.valid && result_ch.ready ||
          cfg_ch.valid && cfg_ch.ready) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < ratm_pkg::RULE_WORDS) begin
        rule_table[cfg_ch.index[ratm_pkg::RULE_IDX_W-1:0]] = cfg_ch.data;
      end
      if (seed_ch.valid && seed_ch.ready) begin
        pending_choices.push_back(predict_choice(seed_ch.row_oldest, seed_ch.row_middle,
                                                 seed_ch.row_newest));
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_choices.size() == 0) begin
          $error("chosen_index: no item outstanding, actual %0d", result_ch.chosen_index);
          mismatches = mismatches + 1;
        end else if (result_ch.chosen_index !== pending_choices[0]) begin
          $error("chosen_index mismatch: expected %0d, actual %0d", pending_choices[0],
                 result_ch.chosen_index);
          mismatches = mismatches + 1;
          void'(pending_choices.pop_front());
        end else begin
          void'(pending_choices.pop_front());
        end
      end
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        result_ch.ready = ($urandom_range(99) >= result_stall_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_seeds(input logic [ratm_pkg::SEED_W-1:0] oldest,
                            input logic [ratm_pkg::SEED_W-1:0] middle,
                            input logic [ratm_pkg::SEED_W-1:0] newest);
    @(negedge clk);
    while ($urandom_range(99) < seed_gap_pct) begin
      seed_ch.valid = 1'b0;
      @(negedge clk);
    end
    seed_ch.valid      = 1'b1;
    seed_ch.row_oldest = oldest;
    seed_ch.row_middle = middle;
    seed_ch.row_newest = newest;
    @(posedge clk);
    while (!seed_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random_seeds();
    if ($urandom_range(7) == 0) begin
      send_seeds(8'(1 << $urandom_range(7)), 8'(1 << $urandom_range(7)),
                 8'(1 << $urandom_range(7)));
    end else begin
      send_seeds(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic write_rule(input int idx, input logic [ratm_pkg::RULE_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = ratm_pkg::CFG_IDX_W'(idx);
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic cfg_quiet();
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_all_rules(input logic [ratm_pkg::RULE_W-1:0] low_half,
                                 input logic [ratm_pkg::RULE_W-1:0] high_half);
    for (int k = RULE_WORD_0; k <= RULE_WORD_7; k++) begin
      write_rule(k, (k < RULE_WORD_4) ? low_half : high_half);
    end
    cfg_quiet();
  endtask

  task automatic drain();
    @(negedge clk);
    seed_ch.valid = 1'b0;
    while (pending_choices.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    seed_gap_pct     = gap_pct;
    result_stall_pct = stall_pct;
  endtask

  task automatic test_reset_rules();
    send_seeds(8'h00, 8'h00, 8'h00);
    send_seeds(8'hFF, 8'hFF, 8'hFF);
    send_seeds(8'hA5, 8'h3C, 8'h96);
    drain();
  endtask

  // Every new cell copies its left neighbour, so the newest row rotates round the ring.
  task automatic test_shift_rule();
    write_all_rules(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_seeds(8'h00, 8'h00, 8'h00);
    send_seeds(8'hFF, 8'hFF, 8'hFF);
    send_seeds(8'h00, 8'h00, 8'h01);
    send_seeds(8'h00, 8'h00, 8'h80);
    send_seeds(8'h00, 8'h00, 8'h20);
    send_seeds(8'hFF, 8'hFF, 8'h7F);
    send_seeds(8'h55, 8'hAA, 8'h81);
    send_seeds(8'h01, 8'h80, 8'h42);
    drain();
  endtask

  // Every new cell takes the right neighbour of the oldest row, with wrap at cell 7.
  task automatic test_oldest_right_rule();
    write_all_rules(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_seeds(8'h01, 8'h00, 8'h00);
    send_seeds(8'h80, 8'h00, 8'h00);
    send_seeds(8'h00, 8'h01, 8'h00);
    send_seeds(8'hFF, 8'h00, 8'hFF);
    send_seeds(8'h00, 8'hFF, 8'h00);
    send_seeds(8'h81, 8'h18, 8'h24);
    drain();
  endtask

  // Indexes past the last rule word must leave the table untouched.
  task automatic test_ignored_indexes();
    write_all_rules(64'hFFFF_0000_FFFF_0000, 64'hFFFF_0000_FFFF_0000);
    for (int k = ratm_pkg::RULE_WORDS; k < (1 << ratm_pkg::CFG_IDX_W); k++) begin
      write_rule(k, {$urandom, $urandom});
    end
    cfg_quiet();
    send_seeds(8'h00, 8'h01, 8'h00);
    send_seeds(8'h00, 8'h80, 8'h00);
    send_seeds(8'hF0, 8'h0F, 8'h3C);
    send_seeds(8'h00, 8'hFF, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [ratm_pkg::RULE_W-1:0] word;
    for (int setting = 0; setting < 4; setting++) begin
      for (int k = RULE_WORD_0; k <= RULE_WORD_7; k++) begin
        unique case (setting)
          0: word = {$urandom, $urandom};
          1: word = '1;
          2: word = {$urandom, $urandom} & {$urandom, $urandom};
          default: word = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        write_rule(k, word);
      end
      cfg_quiet();
      for (int phase = 0; phase < 4; phase++) begin
        unique case (phase)
          0: set_idling(0, 0);
          1: set_idling(IDLE_HEAVY, 0);
          2: set_idling(0, IDLE_HEAVY);
          default: set_idling(IDLE_BOTH, IDLE_BOTH);
        endcase
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          send_random_seeds();
        end
      end
      drain();
    end
    set_idling(0, 0);
  endtask

  // The output is held back long enough for the pipeline to fill and stall the input.
  task automatic test_output_hold();
    set_idling(0, 0);
    stall_left = LONG_HOLD;
    for (int n = 0; n < 60; n++) begin
      send_random_seeds();
    end
    drain();
    for (int n = 0; n < 20; n++) begin
      send_random_seeds();
    end
    drain();
  endtask

  initial begin
    rst                = 1'b1;
    mismatches         = 0;
    quiet_cycles       = 0;
    stall_left         = 0;
    seed_ch.valid      = 1'b0;
    seed_ch.row_oldest = '0;
    seed_ch.row_middle = '0;
    seed_ch.row_newest = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    for (int k = RULE_WORD_0; k <= RULE_WORD_7; k++) begin
      rule_table[k] = '0;
    end
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_rules();
    test_shift_rule();
    test_oldest_right_rule();
    test_ignored_indexes();
    test_random_traffic();
    test_output_hold();

    repeat (ratm_pkg::STAGES + 8) @(posedge clk);
    if (mismatches == 0 && pending_choices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
